>>> rtl/latency_histogram_sequence_monitor_unit_macros.svh
// Assertion macros shared by the latency histogram sequence monitor RTL.
`ifndef LATENCY_HISTOGRAM_SEQUENCE_MONITOR_UNIT_MACROS_SVH
`define LATENCY_HISTOGRAM_SEQUENCE_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LHSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LHSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lhsm_pkg.sv
// Shared types, constants and helper functions of the latency histogram monitor.
package lhsm_pkg;

    // Default configuration of the top level.
    localparam int LHSM_DECADES   = 4;
    localparam int LHSM_TIME_BITS = 48;

    // Fixed field widths.
    localparam int TS_W   = 48;
    localparam int SEQ_W  = 64;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 64;
    localparam int DEC_W  = 2;
    localparam int SLOT_W = 7;

    // Histogram geometry: each decade occupies one row of 2**SLOT_W words.
    localparam int SLOTS     = 100;
    localparam int SLOT_ROWS = 2 ** SLOT_W;

    // Depth of the queue between front and back end; must be a power of two.
    localparam int Q_DEPTH = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Upper bounds of the four decades.
    localparam logic [TS_W-1:0] DEC_LIMIT_0 = 48'd100;
    localparam logic [TS_W-1:0] DEC_LIMIT_1 = 48'd1000;
    localparam logic [TS_W-1:0] DEC_LIMIT_2 = 48'd10000;
    localparam logic [TS_W-1:0] DEC_LIMIT_3 = 48'd100000;

    // Decade code of a latency beyond the last decade.
    localparam logic [2:0] DEC_NONE = 3'd4;

    // Reciprocal multipliers for the slot divisions; exact over each decade's range.
    localparam logic [7:0]  RCP_DIV10   = 8'd205;
    localparam int          SH_DIV10    = 11;
    localparam logic [12:0] RCP_DIV100  = 13'd5243;
    localparam int          SH_DIV100   = 19;
    localparam logic [17:0] RCP_DIV1000 = 18'd134218;
    localparam int          SH_DIV1000  = 27;

    typedef enum logic [2:0] {
        ST_IN_ORDER = 3'd0,
        ST_GAP      = 3'd1,
        ST_DUP      = 3'd2,
        ST_STALE    = 3'd3,
        ST_FUTURE   = 3'd4,
        ST_NO_STAMP = 3'd5,
        ST_BIN_READ = 3'd6
    } t_status;

    typedef struct packed {
        logic              mode;
        logic [TS_W-1:0]   sent_time_ms;
        logic [TS_W-1:0]   arrival_time_ms;
        logic [SEQ_W-1:0]  sequence_number;
        logic [DEC_W-1:0]  bin_decade;
        logic [SLOT_W-1:0] bin_slot;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [TS_W-1:0]  value;
        logic [CNT_W-1:0] record_count;
        logic [CNT_W-1:0] dropped_count;
        logic [CNT_W-1:0] duplicate_count;
        logic [CNT_W-1:0] stale_count;
        logic [CNT_W-1:0] future_count;
        logic [CNT_W-1:0] no_stamp_count;
        logic [CNT_W-1:0] overflow_count;
        logic [TS_W-1:0]  least_latency;
        logic [TS_W-1:0]  peak_latency;
        logic [SUM_W-1:0] latency_sum;
    } t_out_item;

    typedef struct packed {
        logic [TS_W-1:0] start_time_ms;
    } t_cfg_item;

    // Classified work item handed from the front end to the back end.
    typedef struct packed {
        t_status           status;
        logic [TS_W-1:0]   latency;
        logic              hist_hit;
        logic              overflow;
        logic [DEC_W-1:0]  hist_decade;
        logic [SLOT_W-1:0] hist_slot;
        logic              drop_sat;
        logic [CNT_W-1:0]  drop_low;
    } t_job;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic clearing;
        logic hist_we;
    } t_back_stat;

    // Increment that sticks at the counter maximum.
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        return (&x) ? x : x + 1'b1;
    endfunction

endpackage

>>> rtl/lhsm_chan_if.sv
// Valid/ready channel interface carrying one payload item per transfer.
interface lhsm_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/lhsm_front.sv
// Front end: accepts items, classifies stamps, checks sequence and computes the bin.
module lhsm_front import lhsm_pkg::*; #(
    parameter int DECADES   = LHSM_DECADES,
    parameter int TIME_BITS = LHSM_TIME_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_hold,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  t_cfg_item i_cfg_item,
    output logic      o_push,
    output t_job      o_job,
    input  logic      i_full
);

    localparam int TB = (TIME_BITS < TS_W) ? TIME_BITS : TS_W;
    localparam logic [TS_W-1:0] TIME_MASK = {TS_W{1'b1}} >> (TS_W - TB);

    typedef struct packed {
        t_status           status;
        logic [TS_W-1:0]   latency;
        logic [SEQ_W-1:0]  seq;
        logic              rd_hit;
        logic [DEC_W-1:0]  rd_decade;
        logic [SLOT_W-1:0] rd_slot;
    } t_f1;

    logic [TS_W-1:0]  r_start;
    logic             r_f1_v;
    t_f1              r_f1;
    t_f1              n_f1;
    logic [SEQ_W-1:0] r_exp_seq;
    logic [SEQ_W-1:0] n_exp_seq;

    logic [TS_W-1:0] sent;
    logic [TS_W-1:0] now;
    logic [TS_W-1:0] start;
    logic            in_acc;
    logic            rec_valid;

    logic [SEQ_W:0]    seq_diff;
    logic [2:0]        dec;
    logic [SLOT_W-1:0] slot;
    logic              dec_ok;
    logic [17:0]       prod10;
    logic [26:0]       prod100;
    logic [34:0]       prod1000;

    assign o_cfg_ready = 1'b1;
    assign o_push      = r_f1_v && !i_full;
    assign o_in_ready  = (!r_f1_v || !i_full) && !i_hold;
    assign in_acc      = i_in_valid && o_in_ready;

    // Stamp classification of an incoming item.
    always_comb begin
        sent  = i_in_item.sent_time_ms & TIME_MASK;
        now   = i_in_item.arrival_time_ms & TIME_MASK;
        start = r_start & TIME_MASK;
        n_f1           = '0;
        n_f1.seq       = i_in_item.sequence_number;
        n_f1.rd_decade = i_in_item.bin_decade;
        n_f1.rd_slot   = i_in_item.bin_slot;
        n_f1.rd_hit    = ({1'b0, i_in_item.bin_decade} < 3'(DECADES))
                      && (i_in_item.bin_slot < SLOT_W'(SLOTS));
        if (i_in_item.mode) begin
            n_f1.status = ST_BIN_READ;
        end else if (sent == '0) begin
            n_f1.status = ST_NO_STAMP;
        end else if (sent < start) begin
            n_f1.status = ST_STALE;
        end else if (now < sent) begin
            n_f1.status = ST_FUTURE;
        end else begin
            n_f1.status  = ST_IN_ORDER;
            n_f1.latency = now - sent;
        end
    end

    // Slot within each decade by reciprocal multiplication.
    assign prod10   = {8'b0, r_f1.latency[9:0]} * {10'b0, RCP_DIV10};
    assign prod100  = {13'b0, r_f1.latency[13:0]} * {14'b0, RCP_DIV100};
    assign prod1000 = {18'b0, r_f1.latency[16:0]} * {17'b0, RCP_DIV1000};

    // Decade selection of the latency.
    always_comb begin
        if (r_f1.latency < DEC_LIMIT_0) begin
            dec  = 3'd0;
            slot = r_f1.latency[SLOT_W-1:0];
        end else if (r_f1.latency < DEC_LIMIT_1) begin
            dec  = 3'd1;
            slot = prod10[SH_DIV10 +: SLOT_W];
        end else if (r_f1.latency < DEC_LIMIT_2) begin
            dec  = 3'd2;
            slot = prod100[SH_DIV100 +: SLOT_W];
        end else if (r_f1.latency < DEC_LIMIT_3) begin
            dec  = 3'd3;
            slot = prod1000[SH_DIV1000 +: SLOT_W];
        end else begin
            dec  = DEC_NONE;
            slot = '0;
        end
        dec_ok = dec < 3'(DECADES);
    end

    // Sequence check against the expected number and job assembly.
    always_comb begin
        rec_valid = r_f1.status == ST_IN_ORDER;
        seq_diff  = {1'b0, r_f1.seq} - {1'b0, r_exp_seq};
        n_exp_seq = r_f1.seq + 1'b1;
        o_job          = '0;
        o_job.status   = r_f1.status;
        o_job.latency  = r_f1.latency;
        o_job.drop_sat = |seq_diff[SEQ_W-1:CNT_W];
        o_job.drop_low = seq_diff[CNT_W-1:0];
        if (r_f1.status == ST_BIN_READ) begin
            o_job.hist_hit    = r_f1.rd_hit;
            o_job.hist_decade = r_f1.rd_decade;
            o_job.hist_slot   = r_f1.rd_slot;
        end else begin
            o_job.hist_hit    = rec_valid && dec_ok;
            o_job.overflow    = rec_valid && !dec_ok;
            o_job.hist_decade = dec[DEC_W-1:0];
            o_job.hist_slot   = slot;
        end
        if (rec_valid && (r_f1.seq != '0) && (r_f1.seq != r_exp_seq)) begin
            o_job.status = seq_diff[SEQ_W] ? ST_DUP : ST_GAP;
        end
    end

    // Control state: start register, stage valid and expected sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_f1_v    <= 1'b0;
            r_exp_seq <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_start <= i_cfg_item.start_time_ms;
            end
            if (in_acc) begin
                r_f1_v <= 1'b1;
            end else if (o_push) begin
                r_f1_v <= 1'b0;
            end
            if (o_push && rec_valid) begin
                r_exp_seq <= n_exp_seq;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_f1 <= n_f1;
        end
    end

endmodule

>>> rtl/lhsm_queue.sv
// Short job queue that decouples the front end from the back end.
module lhsm_queue import lhsm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output logic    o_valid,
    output t_job    o_job,
    output logic    o_full,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);

    t_job              r_entries [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == CNT_QW'(Q_DEPTH);
    assign o_job   = r_entries[r_rd_ptr];

    assign o_stat.push = i_push;
    assign o_stat.pop  = i_pop;
    assign o_stat.full = o_full;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_job;
        end
    end

endmodule

>>> rtl/lhsm_back.sv
// Back end: statistics update, histogram read-modify-write and result register.
module lhsm_back import lhsm_pkg::*; #(
    parameter int DECADES = LHSM_DECADES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_item,
    output t_back_stat o_stat
);

    localparam int HIST_DEPTH = DECADES * SLOT_ROWS;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);

    // Histogram memory and clearing sweep.
    logic [CNT_W-1:0]  r_hist [HIST_DEPTH];
    logic [CNT_W-1:0]  r_rd_data;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    // Running statistics.
    logic [CNT_W-1:0] r_received, n_received;
    logic [CNT_W-1:0] r_dropped, n_dropped;
    logic [CNT_W-1:0] r_duplicate, n_duplicate;
    logic [CNT_W-1:0] r_stale, n_stale;
    logic [CNT_W-1:0] r_future, n_future;
    logic [CNT_W-1:0] r_no_stamp, n_no_stamp;
    logic [CNT_W-1:0] r_overflow, n_overflow;
    logic [TS_W-1:0]  r_min, n_min;
    logic [TS_W-1:0]  r_max, n_max;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SUM_W:0]   sum_ext;
    logic [CNT_W:0]   drop_tot;

    // Histogram stage and output register.
    logic              r_b2_v;
    t_out_item         r_b2_item;
    t_out_item         n_b2_item;
    logic              r_b2_hit;
    logic              r_b2_read;
    logic [ADDR_W-1:0] r_b2_addr;
    logic              r_fwd_v;
    logic [CNT_W-1:0]  r_fwd_data;
    logic              r_out_v;
    t_out_item         r_out_item;
    t_out_item         n_out_item;

    logic              b2_adv;
    logic [ADDR_W-1:0] job_addr;
    logic [CNT_W-1:0]  hist_cur;
    logic [CNT_W-1:0]  hist_bump;
    logic              hist_we;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CNT_W-1:0]  mem_wd;

    assign job_addr  = ADDR_W'({i_job.hist_decade, i_job.hist_slot});
    assign b2_adv    = r_b2_v && (!r_out_v || i_out_ready);
    assign o_pop     = i_q_valid && !r_clearing && (!r_b2_v || b2_adv);

    // Read data with forwarding of the write made on the same edge as the read.
    assign hist_cur  = r_fwd_v ? r_fwd_data : r_rd_data;
    assign hist_bump = sat_inc(hist_cur);
    assign hist_we   = b2_adv && r_b2_hit && !r_b2_read;

    assign mem_we = r_clearing || hist_we;
    assign mem_wa = r_clearing ? r_clr_addr : r_b2_addr;
    assign mem_wd = r_clearing ? '0 : hist_bump;

    assign o_out_valid    = r_out_v;
    assign o_out_item     = r_out_item;
    assign o_stat.clearing = r_clearing;
    assign o_stat.hist_we  = hist_we;

    // Statistics update for the job at the queue head.
    always_comb begin
        n_received  = r_received;
        n_dropped   = r_dropped;
        n_duplicate = r_duplicate;
        n_stale     = r_stale;
        n_future    = r_future;
        n_no_stamp  = r_no_stamp;
        n_overflow  = r_overflow;
        n_min       = r_min;
        n_max       = r_max;
        n_sum       = r_sum;
        sum_ext     = {1'b0, r_sum} + (SUM_W + 1)'(i_job.latency);
        drop_tot    = {1'b0, r_dropped} + {1'b0, i_job.drop_low};
        if (i_job.status != ST_BIN_READ) begin
            n_received = sat_inc(r_received);
        end
        case (i_job.status)
            ST_NO_STAMP: begin
                n_no_stamp = sat_inc(r_no_stamp);
            end
            ST_STALE: begin
                n_stale = sat_inc(r_stale);
            end
            ST_FUTURE: begin
                n_future = sat_inc(r_future);
            end
            ST_IN_ORDER, ST_GAP, ST_DUP: begin
                if (i_job.latency > r_max) begin
                    n_max = i_job.latency;
                end
                // A zero minimum means no latency has been kept yet.
                if ((r_min == '0) || (i_job.latency < r_min)) begin
                    n_min = i_job.latency;
                end
                n_sum = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
                if (i_job.overflow) begin
                    n_overflow = sat_inc(r_overflow);
                end
                if (i_job.status == ST_GAP) begin
                    n_dropped = (i_job.drop_sat || drop_tot[CNT_W] || (&drop_tot[CNT_W-1:0]))
                              ? CNT_MAX : drop_tot[CNT_W-1:0];
                end
                if (i_job.status == ST_DUP) begin
                    n_duplicate = sat_inc(r_duplicate);
                end
            end
            default: begin
            end
        endcase
    end

    // Result snapshot taken as the job leaves the queue.
    always_comb begin
        n_b2_item                 = '0;
        n_b2_item.status          = i_job.status;
        n_b2_item.value           = i_job.latency;
        n_b2_item.record_count    = n_received;
        n_b2_item.dropped_count   = n_dropped;
        n_b2_item.duplicate_count = n_duplicate;
        n_b2_item.stale_count     = n_stale;
        n_b2_item.future_count    = n_future;
        n_b2_item.no_stamp_count  = n_no_stamp;
        n_b2_item.overflow_count  = n_overflow;
        n_b2_item.least_latency   = n_min;
        n_b2_item.peak_latency    = n_max;
        n_b2_item.latency_sum     = n_sum;
    end

    // A bin read takes its value from the histogram word.
    always_comb begin
        n_out_item = r_b2_item;
        if (r_b2_read) begin
            n_out_item.value = r_b2_hit ? TS_W'(hist_cur) : '0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_received  <= '0;
            r_dropped   <= '0;
            r_duplicate <= '0;
            r_stale     <= '0;
            r_future    <= '0;
            r_no_stamp  <= '0;
            r_overflow  <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_b2_v      <= 1'b0;
            r_fwd_v     <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(HIST_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (o_pop) begin
                r_received  <= n_received;
                r_dropped   <= n_dropped;
                r_duplicate <= n_duplicate;
                r_stale     <= n_stale;
                r_future    <= n_future;
                r_no_stamp  <= n_no_stamp;
                r_overflow  <= n_overflow;
                r_min       <= n_min;
                r_max       <= n_max;
                r_sum       <= n_sum;
                r_fwd_v     <= hist_we && (r_b2_addr == job_addr);
            end
            if (o_pop) begin
                r_b2_v <= 1'b1;
            end else if (b2_adv) begin
                r_b2_v <= 1'b0;
            end
            if (b2_adv) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Stage and output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b2_item  <= n_b2_item;
            r_b2_hit   <= i_job.hist_hit;
            r_b2_read  <= i_job.status == ST_BIN_READ;
            r_b2_addr  <= job_addr;
            r_fwd_data <= hist_bump;
        end
        if (b2_adv) begin
            r_out_item <= n_out_item;
        end
    end

    // Histogram memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[mem_wa] <= mem_wd;
        end
        if (o_pop && i_job.hist_hit) begin
            r_rd_data <= r_hist[job_addr];
        end
    end

endmodule

>>> rtl/latency_histogram_sequence_monitor_unit.sv
// Top level of the message latency histogram and sequence monitor.
`include "latency_histogram_sequence_monitor_unit_macros.svh"

// Each input transfer is either a message record or a histogram bin read, and each
// produces exactly one result transfer carrying a status, a value and a snapshot of
// all counters, min, max and latency sum. The unit sustains one item per clock when
// the output is not stalled and no clear is running; the figure is set by the back
// end, which updates the statistics and performs the histogram read-modify-write for
// one item per cycle, with forwarding between back-to-back updates of the same bin.
// Between its input transfer and its result an item passes the classifying front
// stage, the four-entry job queue and the histogram read stage, after which the output
// register presents it. After reset all DECADES*128 words of the histogram memory are
// swept to zero, during which no input is taken; configuration writes are accepted at
// any time but should only be issued while the unit is idle.
module latency_histogram_sequence_monitor_unit import lhsm_pkg::*; #(
    parameter int DECADES   = LHSM_DECADES,
    parameter int TIME_BITS = LHSM_TIME_BITS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    lhsm_chan_if.sink   i_in,
    lhsm_chan_if.source o_out,
    lhsm_chan_if.sink   i_cfg
);

    logic       q_push;
    t_job       q_in_job;
    logic       q_pop;
    logic       q_valid;
    t_job       q_out_job;
    logic       q_full;
    t_q_stat    q_stat;
    t_back_stat b_stat;

    // Front end: classification and sequence check.
    lhsm_front #(
        .DECADES   (DECADES),
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_in_item   (i_in.payload),
        .i_hold      (b_stat.clearing),
        .i_cfg_valid (i_cfg.valid),
        .o_cfg_ready (i_cfg.ready),
        .i_cfg_item  (i_cfg.payload),
        .o_push      (q_push),
        .o_job       (q_in_job),
        .i_full      (q_full)
    );

    // Job queue between the two ends.
    lhsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job),
        .o_full  (q_full),
        .o_stat  (q_stat)
    );

    // Back end: statistics, histogram and results.
    lhsm_back #(
        .DECADES (DECADES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (q_out_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (o_out.payload),
        .o_stat      (b_stat)
    );

    // No input transfer while the histogram is being cleared.
    `LHSM_ASSERT_NOW(a_clear_blocks_input, i_clk, i_rst_n, b_stat.clearing, !i_in.ready, "input taken during histogram clear")
    // A stalled result never lets a histogram update through.
    `LHSM_ASSERT_NOW(a_stall_no_bump, i_clk, i_rst_n, o_out.valid && !o_out.ready, !b_stat.hist_we, "histogram written while result stalled")
    // The front end never pushes into a full queue.
    `LHSM_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, q_stat.push, !q_stat.full, "job pushed into full queue")
    // A full queue that is not drained stays closed in the next cycle.
    `LHSM_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, q_stat.full && !q_stat.pop, !q_stat.push, "push after undrained full queue")

endmodule

>>> verif/latency_histogram_sequence_monitor_unit_tb.sv
// Self-checking testbench for the latency histogram and sequence monitor unit.
module latency_histogram_sequence_monitor_unit_tb;
    import lhsm_pkg::*;

    localparam logic [TS_W-1:0]  TS_MAX      = {TS_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};
    localparam int               DRAIN_WAIT  = 8;
    localparam int               CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n;

    lhsm_chan_if #(.t_payload(t_in_item))  in_ch ();
    lhsm_chan_if #(.t_payload(t_out_item)) out_ch ();
    lhsm_chan_if #(.t_payload(t_cfg_item)) cfg_ch ();

    latency_histogram_sequence_monitor_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Shadow copy of the monitor state, updated at every accepted input transfer.
    logic [CNT_W-1:0] hist_bins [LHSM_DECADES][SLOTS];
    logic [SEQ_W-1:0] next_seq;
    logic [CNT_W-1:0] rx_cnt, drop_cnt, dup_cnt, stale_cnt, future_cnt, nostamp_cnt, ovf_cnt;
    logic [TS_W-1:0]  lat_min, lat_max, start_ms;
    logic [SUM_W-1:0] lat_sum;

    t_out_item expected_reports[$];

    bit in_driving   = 1'b0;
    bit idling_on    = 1'b1;
    int stall_left   = 0;
    int mismatch_count = 0;
    int reports_checked = 0;
    int records_sent = 0;
    int bin_reads_sent = 0;
    int start_settings = 0;
    int cycle_count = 0;

    // Clock with a 12 unit period.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d reports outstanding", $time, expected_reports.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output back-pressure in random bursts while idling is enabled.
    always @(negedge clk) begin
        if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    function automatic logic [CNT_W-1:0] bump32(input logic [CNT_W-1:0] x);
        return (x == CNT_MAX) ? x : x + 1'b1;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_between(input logic [63:0] lo, input logic [63:0] hi);
        return lo + (rand64() % (hi - lo + 64'd1));
    endfunction

    task automatic clear_monitor_model();
        for (int d = 0; d < LHSM_DECADES; d++)
            for (int s = 0; s < SLOTS; s++)
                hist_bins[d][s] = '0;
        next_seq    = '0;
        rx_cnt      = '0;
        drop_cnt    = '0;
        dup_cnt     = '0;
        stale_cnt   = '0;
        future_cnt  = '0;
        nostamp_cnt = '0;
        ovf_cnt     = '0;
        lat_min     = '0;
        lat_max     = '0;
        lat_sum     = '0;
        start_ms    = '0;
    endtask

    // Compute the report for one item and advance the shadow state.
    task automatic predict_monitor_report(input t_in_item it);
        t_out_item        r;
        logic [TS_W-1:0]  lat;
        logic [SEQ_W-1:0] gap;
        logic [CNT_W-1:0] room;
        int               d;
        int               s;
        bit               hit;
        r = '0;
        if (it.mode) begin
            r.status = ST_BIN_READ;
            if (int'(it.bin_decade) < LHSM_DECADES && int'(it.bin_slot) < SLOTS)
                r.value = TS_W'(hist_bins[it.bin_decade][it.bin_slot]);
        end else begin
            rx_cnt = bump32(rx_cnt);
            if (it.sent_time_ms == '0) begin
                nostamp_cnt = bump32(nostamp_cnt);
                r.status = ST_NO_STAMP;
            end else if (it.sent_time_ms < start_ms) begin
                stale_cnt = bump32(stale_cnt);
                r.status = ST_STALE;
            end else if (it.arrival_time_ms < it.sent_time_ms) begin
                future_cnt = bump32(future_cnt);
                r.status = ST_FUTURE;
            end else begin
                lat = it.arrival_time_ms - it.sent_time_ms;
                r.value = lat;
                if (lat > lat_max)
                    lat_max = lat;
                if (lat_min == '0 || lat < lat_min)
                    lat_min = lat;
                if (lat_sum > SUM_MAX - SUM_W'(lat))
                    lat_sum = SUM_MAX;
                else
                    lat_sum = lat_sum + SUM_W'(lat);
                // Decade histogram: 1, 10, 100 and 1000 ms slots.
                hit = 1'b1;
                if (lat < 100) begin
                    d = 0;
                    s = int'(lat);
                end else if (lat < 1000) begin
                    d = 1;
                    s = int'(lat / 10);
                end else if (lat < 10000) begin
                    d = 2;
                    s = int'(lat / 100);
                end else if (lat < 100000) begin
                    d = 3;
                    s = int'(lat / 1000);
                end else begin
                    hit = 1'b0;
                end
                if (hit && d < LHSM_DECADES)
                    hist_bins[d][s] = bump32(hist_bins[d][s]);
                else
                    ovf_cnt = bump32(ovf_cnt);
                // Sequence tracking; zero means the sender restarted.
                r.status = ST_IN_ORDER;
                if (it.sequence_number != '0 && it.sequence_number != next_seq) begin
                    if (it.sequence_number > next_seq) begin
                        gap  = it.sequence_number - next_seq;
                        room = CNT_MAX - drop_cnt;
                        drop_cnt = (gap >= SEQ_W'(room)) ? CNT_MAX : drop_cnt + CNT_W'(gap);
                        r.status = ST_GAP;
                    end else begin
                        dup_cnt = bump32(dup_cnt);
                        r.status = ST_DUP;
                    end
                end
                next_seq = it.sequence_number + 1'b1;
            end
        end
        r.record_count    = rx_cnt;
        r.dropped_count   = drop_cnt;
        r.duplicate_count = dup_cnt;
        r.stale_count     = stale_cnt;
        r.future_count    = future_cnt;
        r.no_stamp_count  = nostamp_cnt;
        r.overflow_count  = ovf_cnt;
        r.least_latency   = lat_min;
        r.peak_latency    = lat_max;
        r.latency_sum     = lat_sum;
        expected_reports.push_back(r);
    endtask

    // Present one item, wait for its transfer, then optionally leave a gap.
    task automatic send_item(input t_in_item it);
        in_ch.payload <= it;
        in_ch.valid   <= 1'b1;
        in_driving = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        predict_monitor_report(it);
        if (it.mode)
            bin_reads_sent++;
        else
            records_sent++;
        @(negedge clk);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            in_driving = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    task automatic release_input();
        if (in_driving) begin
            in_ch.valid <= 1'b0;
            in_driving = 1'b0;
        end
    endtask

    // Stop sending and wait until every report has come back.
    task automatic wait_drain();
        release_input();
        while (expected_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Register write; only issued while the unit is idle.
    task automatic write_start_time(input logic [TS_W-1:0] t);
        cfg_ch.payload <= '{start_time_ms: t};
        cfg_ch.valid   <= 1'b1;
        do @(posedge clk); while (!cfg_ch.ready);
        start_ms = t;
        start_settings++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_in_item noise_item();
        t_in_item it;
        it.mode            = 1'($urandom);
        it.sent_time_ms    = TS_W'(rand64());
        it.arrival_time_ms = TS_W'(rand64());
        it.sequence_number = rand64();
        it.bin_decade      = DEC_W'($urandom);
        it.bin_slot        = SLOT_W'($urandom);
        return it;
    endfunction

    function automatic t_in_item record_item(input logic [TS_W-1:0] sent,
                                             input logic [TS_W-1:0] arrival,
                                             input logic [SEQ_W-1:0] seq);
        t_in_item it;
        it = noise_item();
        it.mode            = 1'b0;
        it.sent_time_ms    = sent;
        it.arrival_time_ms = arrival;
        it.sequence_number = seq;
        return it;
    endfunction

    function automatic t_in_item bin_item(input int dec, input int slot);
        t_in_item it;
        it = noise_item();
        it.mode       = 1'b1;
        it.bin_decade = DEC_W'(dec);
        it.bin_slot   = SLOT_W'(slot);
        return it;
    endfunction

    function automatic logic [TS_W-1:0] pick_latency();
        logic [TS_W-1:0] lat;
        case ($urandom_range(0, 9))
            0, 1, 2: lat = TS_W'($urandom_range(0, 99));
            3, 4:    lat = TS_W'($urandom_range(100, 999));
            5, 6:    lat = TS_W'($urandom_range(1000, 9999));
            7:       lat = TS_W'($urandom_range(10000, 99999));
            8: begin
                case ($urandom_range(0, 8))
                    0: lat = 48'd0;
                    1: lat = 48'd99;
                    2: lat = 48'd100;
                    3: lat = 48'd999;
                    4: lat = 48'd1000;
                    5: lat = 48'd9999;
                    6: lat = 48'd10000;
                    7: lat = 48'd99999;
                    default: lat = 48'd100000;
                endcase
            end
            default: lat = TS_W'(rand_between(100000, TS_MAX));
        endcase
        return lat;
    endfunction

    // Mostly well-formed records: valid stamps and in-order sequence numbers.
    function automatic t_in_item random_record();
        logic [TS_W-1:0]  lo, sent, arrival, lat;
        logic [SEQ_W-1:0] seq;
        int               pick;
        lo   = (start_ms == '0) ? TS_W'(1) : start_ms;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 19))
            0:       seq = '0;
            1, 2:    seq = next_seq + SEQ_W'($urandom_range(1, 5));
            3:       seq = next_seq - SEQ_W'($urandom_range(1, 3));
            4:       seq = rand64();
            default: seq = next_seq;
        endcase
        if (pick < 5) begin
            sent    = '0;
            arrival = TS_W'(rand64());
        end else if (pick < 10 && start_ms > 1) begin
            sent    = TS_W'(rand_between(1, start_ms - 1));
            arrival = TS_W'(rand64());
        end else if (pick < 15 && lo < TS_MAX) begin
            sent    = TS_W'(rand_between(lo + 1, TS_MAX));
            arrival = TS_W'(rand_between(0, sent - 1));
        end else begin
            lat = pick_latency();
            if (lat > TS_MAX - lo)
                lat = TS_MAX - lo;
            if ($urandom_range(0, 1) == 0 && lo + 1000 <= TS_MAX - lat)
                sent = lo + TS_W'($urandom_range(0, 1000));
            else
                sent = TS_W'(rand_between(lo, TS_MAX - lat));
            arrival = sent + lat;
        end
        return record_item(sent, arrival, seq);
    endfunction

    function automatic t_in_item random_traffic_item();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return random_record();
        else if (pick < 9)
            return bin_item($urandom_range(0, 3),
                            ($urandom_range(0, 9) == 0) ? $urandom_range(100, 127)
                                                        : $urandom_range(0, 99));
        else
            return noise_item();
    endfunction

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Check each output transfer against the oldest expected report.
    always @(posedge clk) begin : report_check
        t_out_item want;
        t_out_item got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, status %0d value %0d",
                         $time, got.status, got.value);
                mismatch_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("status", want.status, got.status);
                check_field("value", want.value, got.value);
                check_field("record_count", want.record_count, got.record_count);
                check_field("dropped_count", want.dropped_count, got.dropped_count);
                check_field("duplicate_count", want.duplicate_count, got.duplicate_count);
                check_field("stale_count", want.stale_count, got.stale_count);
                check_field("future_count", want.future_count, got.future_count);
                check_field("no_stamp_count", want.no_stamp_count, got.no_stamp_count);
                check_field("overflow_count", want.overflow_count, got.overflow_count);
                check_field("least_latency", want.least_latency, got.least_latency);
                check_field("peak_latency", want.peak_latency, got.peak_latency);
                check_field("latency_sum", want.latency_sum, got.latency_sum);
                reports_checked++;
            end
        end
    end

    // Bins must read zero after the clearing sweep, and an out-of-range slot reads zero.
    task automatic test_after_reset_bins();
        send_item(bin_item(0, 0));
        send_item(bin_item(3, 99));
        send_item(bin_item(0, 127));
    endtask

    // Missing, stale, future and zero-latency stamps.
    task automatic test_stamp_classes();
        wait_drain();
        write_start_time(48'd1000);
        send_item(record_item(48'd0, 48'd500, 64'd1));
        send_item(record_item(48'd999, 48'd2000, 64'd1));
        send_item(record_item(48'd5000, 48'd4999, 64'd1));
        send_item(record_item(48'd1000, 48'd1000, 64'd0));
    endtask

    // Latencies on both sides of every decade bound, plus the largest one.
    task automatic test_decade_boundaries();
        logic [TS_W-1:0] lats [10];
        lats = '{48'd1, 48'd99, 48'd100, 48'd999, 48'd1000, 48'd9999,
                 48'd10000, 48'd99999, 48'd100000, TS_MAX - 48'd1000};
        foreach (lats[k])
            send_item(record_item(48'd1000, 48'd1000 + lats[k], next_seq));
    endtask

    // Gap, duplicate, restart, and a jump to the top that saturates the drop count.
    task automatic test_sequence_checks();
        send_item(record_item(48'd1000, 48'd1010, next_seq + 64'd5));
        send_item(record_item(48'd1000, 48'd1010, next_seq - 64'd3));
        send_item(record_item(48'd1000, 48'd1010, 64'd0));
        send_item(record_item(48'd1000, 48'd1010, {SEQ_W{1'b1}}));
    endtask

    task automatic test_bin_reads();
        send_item(bin_item(1, 99));
        send_item(bin_item(3, 99));
        send_item(bin_item(2, 100));
    endtask

    // Start time at its maximum: only a stamp at the very top is accepted.
    task automatic test_start_time_extremes();
        wait_drain();
        write_start_time(TS_MAX);
        send_item(record_item(TS_MAX, TS_MAX, next_seq));
        send_item(record_item(TS_MAX - 48'd1, TS_MAX, next_seq));
        wait_drain();
        write_start_time('0);
    endtask

    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++)
            send_item(random_traffic_item());
    endtask

    // Second phase with a mid-range start time; half of it runs without idling.
    task automatic test_mid_start_traffic();
        wait_drain();
        write_start_time(TS_W'(rand_between(1, 48'h8000_0000_0000)));
        test_random_traffic(175);
        idling_on = 1'b0;
        test_random_traffic(175);
        idling_on = 1'b1;
    endtask

    task automatic test_small_start_traffic();
        wait_drain();
        write_start_time(TS_W'($urandom_range(1, 100000)));
        test_random_traffic(250);
    endtask

    // Back-to-back traffic at full rate on both sides.
    task automatic test_closing_burst();
        idling_on = 1'b0;
        test_random_traffic(100);
    endtask

    initial begin
        rst_n = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        clear_monitor_model();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_after_reset_bins();
        test_stamp_classes();
        test_decade_boundaries();
        test_sequence_checks();
        test_bin_reads();
        test_start_time_extremes();
        test_random_traffic(350);
        test_mid_start_traffic();
        test_small_start_traffic();
        test_closing_burst();
        wait_drain();

        $display("Checked %0d reports from %0d records and %0d bin reads over %0d start times.",
                 reports_checked, records_sent, bin_reads_sent, start_settings);
        $display("Final counts: dropped %0d, duplicate %0d, stale %0d, future %0d, no stamp %0d, overflow %0d.",
                 drop_cnt, dup_cnt, stale_cnt, future_cnt, nostamp_cnt, ovf_cnt);
        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
